[src/pst_pkg.sv]
package pst_pkg;

  // Table depth and the widths that follow from it.
  localparam int MAX_VERTICES = 256;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 32;
  localparam int WORD_W       = 2 * COORD_W;

  typedef enum logic [2:0] {
    CMD_APPEND   = 3'd0,
    CMD_SET      = 3'd1,
    CMD_DELETE   = 3'd2,
    CMD_DEL_LAST = 3'd3,
    CMD_FIND     = 3'd4,
    CMD_READ     = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ_WAIT,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_FIND_LO,
    ST_FIND_HI,
    ST_FIND_ISSUE,
    ST_FIND_CMP,
    ST_FINISH
  } state_t;

endpackage

[src/pst_ram.sv]
module pst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[src/polyline_segment_table_unit.sv]
// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  -----------------------------------------------
// command   in         in_valid / in_ready  command, index, x_coord, y_coord
// result    out        out_valid/out_ready  ok, start_x, start_y, end_x, end_y, vertex_count
//
// Every command transfer yields exactly one result transfer. Delete at an index shifts each
// later vertex down with a read and a write, and find runs a binary search over the table.
// Their timing is set by the one memory read port, whose read data is registered, and by the
// shared signed compare.
// Reset clears the vertex count and the handshake state; vertex memory contents persist.
// A stalled result waits in the output register while the next command is already taken.
module polyline_segment_table_unit
  import pst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [7:0]  index,
  input  logic [31:0] x_coord,
  input  logic [31:0] y_coord,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [31:0] start_x,
  output logic [31:0] start_y,
  output logic [31:0] end_x,
  output logic [31:0] end_y,
  output logic [8:0]  vertex_count
);

  // Sequencer state and the command latched at the input transfer.
  state_t               state, state_next;
  cmd_t                 cmd_r, cmd_r_next;
  logic [7:0]           idx_r, idx_r_next;
  logic [COORD_W-1:0]   x_r, x_r_next;
  logic [COORD_W-1:0]   y_r, y_r_next;

  // Table fill level and working registers for shifting and searching.
  logic [CNT_W-1:0]     count, count_next;
  logic [IDX_W-1:0]     k_ptr, k_ptr_next;
  logic [IDX_W-1:0]     lo_idx, lo_idx_next;
  logic [IDX_W-1:0]     hi_idx, hi_idx_next;
  logic [WORD_W-1:0]    s_word, s_word_next;
  logic [WORD_W-1:0]    e_word, e_word_next;
  logic                 res_ok, res_ok_next;

  // Memory port and the shared comparator.
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [WORD_W-1:0]    wr_data;
  logic [IDX_W-1:0]     rd_addr;
  logic [WORD_W-1:0]    rd_data;
  logic [COORD_W-1:0]   cmp_a, cmp_b;
  logic                 cmp_lt;

  // Helper values derived from the registers.
  logic [CNT_W-1:0]     idx_ext;
  logic                 idx_in_range;
  logic [CNT_W-1:0]     count_m1;
  logic [IDX_W-1:0]     last_idx;
  logic [IDX_W:0]       mid_sum;
  logic [IDX_W-1:0]     mid_idx;
  logic [COORD_W-1:0]   rd_x;
  logic [CNT_W:0]       k_plus2;
  logic [CNT_W:0]       idx_plus1;
  logic [IDX_W-1:0]     gap;
  logic                 out_free;

  assign idx_ext      = CNT_W'(idx_r);
  assign idx_in_range = idx_ext < count;
  assign count_m1     = count - CNT_W'(1);
  assign last_idx     = count_m1[IDX_W-1:0];
  assign mid_sum      = {1'b0, lo_idx} + {1'b0, hi_idx};
  assign mid_idx      = mid_sum[IDX_W:1];
  assign rd_x         = rd_data[WORD_W-1:COORD_W];
  assign k_plus2      = (CNT_W+1)'(k_ptr) + (CNT_W+1)'(2);
  assign idx_plus1    = (CNT_W+1)'(idx_ext) + (CNT_W+1)'(1);
  assign out_free     = !out_valid || out_ready;

  // The one signed compare that the compare steps of the find command share.
  assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

  pst_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_VERTICES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Outputs of the sequencer: memory control, comparator operands and input ready.
  always_comb begin
    in_ready = (state == ST_IDLE);
    wr_en    = 1'b0;
    wr_addr  = k_ptr;
    wr_data  = rd_data;
    rd_addr  = k_ptr;
    cmp_a    = rd_x;
    cmp_b    = x_r;
    case (state)
      ST_EXEC: begin
        case (cmd_r)
          CMD_APPEND: begin
            wr_en   = (count < CNT_W'(MAX_VERTICES));
            wr_addr = count[IDX_W-1:0];
            wr_data = {x_r, y_r};
          end
          CMD_SET: begin
            wr_en   = idx_in_range;
            wr_addr = idx_ext[IDX_W-1:0];
            wr_data = {x_r, y_r};
          end
          CMD_FIND: rd_addr = '0;
          CMD_READ: rd_addr = idx_ext[IDX_W-1:0];
          default:  rd_addr = k_ptr;
        endcase
      end
      ST_SHIFT_RD:   rd_addr = k_ptr + IDX_W'(1);
      ST_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = k_ptr;
        wr_data = rd_data;
      end
      ST_FIND_LO: begin
        // Query below the first vertex means no segment.
        rd_addr = last_idx;
        cmp_a   = x_r;
        cmp_b   = rd_x;
      end
      ST_FIND_HI: begin
        // Last vertex below the query means no segment.
        cmp_a = rd_x;
        cmp_b = x_r;
      end
      ST_FIND_ISSUE: rd_addr = mid_idx;
      default:       rd_addr = k_ptr;
    endcase
  end

  // Next state and next values of the working registers.
  always_comb begin
    state_next  = state;
    cmd_r_next  = cmd_r;
    idx_r_next  = idx_r;
    x_r_next    = x_r;
    y_r_next    = y_r;
    count_next  = count;
    k_ptr_next  = k_ptr;
    lo_idx_next = lo_idx;
    hi_idx_next = hi_idx;
    s_word_next = s_word;
    e_word_next = e_word;
    res_ok_next = res_ok;
    gap         = hi_idx - lo_idx;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_r_next = cmd_t'(command);
          idx_r_next = index;
          x_r_next   = x_coord;
          y_r_next   = y_coord;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        s_word_next = '0;
        e_word_next = '0;
        res_ok_next = 1'b0;
        state_next  = ST_FINISH;
        case (cmd_r)
          CMD_APPEND: begin
            if (count < CNT_W'(MAX_VERTICES)) begin
              count_next  = count + CNT_W'(1);
              res_ok_next = 1'b1;
            end
          end
          CMD_SET: res_ok_next = idx_in_range;
          CMD_DELETE: begin
            if (idx_in_range) begin
              k_ptr_next = idx_ext[IDX_W-1:0];
              if (idx_plus1 < (CNT_W+1)'(count)) begin
                state_next = ST_SHIFT_RD;
              end else begin
                count_next  = count_m1;
                res_ok_next = 1'b1;
              end
            end
          end
          CMD_DEL_LAST: begin
            if (count != '0) begin
              count_next  = count_m1;
              res_ok_next = 1'b1;
            end
          end
          CMD_FIND: begin
            if (count >= CNT_W'(2)) begin
              state_next = ST_FIND_LO;
            end
          end
          CMD_READ: begin
            if (idx_in_range) begin
              state_next = ST_READ_WAIT;
            end
          end
          default: state_next = ST_FINISH;
        endcase
      end
      ST_READ_WAIT: begin
        s_word_next = rd_data;
        res_ok_next = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_SHIFT_RD: state_next = ST_SHIFT_WR;
      ST_SHIFT_WR: begin
        k_ptr_next = k_ptr + IDX_W'(1);
        if (k_plus2 < (CNT_W+1)'(count)) begin
          state_next = ST_SHIFT_RD;
        end else begin
          count_next  = count_m1;
          res_ok_next = 1'b1;
          state_next  = ST_FINISH;
        end
      end
      ST_FIND_LO: begin
        if (cmp_lt) begin
          state_next = ST_FINISH;
        end else begin
          s_word_next = rd_data;
          state_next  = ST_FIND_HI;
        end
      end
      ST_FIND_HI: begin
        lo_idx_next = '0;
        hi_idx_next = last_idx;
        if (cmp_lt) begin
          s_word_next = '0;
          state_next  = ST_FINISH;
        end else begin
          e_word_next = rd_data;
          if (last_idx > IDX_W'(1)) begin
            state_next = ST_FIND_ISSUE;
          end else begin
            res_ok_next = 1'b1;
            state_next  = ST_FINISH;
          end
        end
      end
      ST_FIND_ISSUE: state_next = ST_FIND_CMP;
      ST_FIND_CMP: begin
        if (cmp_lt) begin
          lo_idx_next = mid_idx;
          s_word_next = rd_data;
          gap         = hi_idx - mid_idx;
        end else begin
          hi_idx_next = mid_idx;
          e_word_next = rd_data;
          gap         = mid_idx - lo_idx;
        end
        if (gap > IDX_W'(1)) begin
          state_next = ST_FIND_ISSUE;
        end else begin
          res_ok_next = 1'b1;
          state_next  = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers; the result register loads when the sequencer hands off a result.
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_r_next;
    idx_r  <= idx_r_next;
    x_r    <= x_r_next;
    y_r    <= y_r_next;
    k_ptr  <= k_ptr_next;
    lo_idx <= lo_idx_next;
    hi_idx <= hi_idx_next;
    s_word <= s_word_next;
    e_word <= e_word_next;
    res_ok <= res_ok_next;
    if (state == ST_FINISH && out_free) begin
      ok           <= res_ok;
      start_x      <= s_word[WORD_W-1:COORD_W];
      start_y      <= s_word[COORD_W-1:0];
      end_x        <= e_word[WORD_W-1:COORD_W];
      end_y        <= e_word[COORD_W-1:0];
      vertex_count <= 9'(count);
    end
  end

endmodule
